[rtl/core/mck_pkg.sv]
package mck_pkg;

    localparam int CHAR_W = 8;
    localparam int DUR_W  = 16;
    localparam int CNT_W  = 3;
    localparam int PAT_W  = 4;
    localparam int IDX_W  = 3;

    localparam logic [IDX_W-1:0] REG_DOT      = 3'd0;
    localparam logic [IDX_W-1:0] REG_DASH     = 3'd1;
    localparam logic [IDX_W-1:0] REG_ELEM_GAP = 3'd2;
    localparam logic [IDX_W-1:0] REG_CHAR_GAP = 3'd3;
    localparam logic [IDX_W-1:0] REG_WORD_GAP = 3'd4;
    localparam logic [IDX_W-1:0] REG_SENT_GAP = 3'd5;

    localparam logic [DUR_W-1:0] DOT_RST      = 16'd250;
    localparam logic [DUR_W-1:0] DASH_RST     = 16'd750;
    localparam logic [DUR_W-1:0] ELEM_GAP_RST = 16'd250;
    localparam logic [DUR_W-1:0] CHAR_GAP_RST = 16'd750;
    localparam logic [DUR_W-1:0] WORD_GAP_RST = 16'd1750;
    localparam logic [DUR_W-1:0] SENT_GAP_RST = 16'd2500;

    localparam logic [CHAR_W-1:0] CH_A       = 8'h61;
    localparam logic [CHAR_W-1:0] CH_Z       = 8'h7A;
    localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
    localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0A;

    localparam int NUM_LETTERS = 26;

    // [6:4] element count, [3:0] elements, first in highest used bit, 1 = dash
    localparam logic [7:0] LETTER_CODE [NUM_LETTERS] = '{
        8'h21, 8'h48, 8'h4A, 8'h34, 8'h10, 8'h42, 8'h36, 8'h40, 8'h20, 8'h47,
        8'h35, 8'h44, 8'h23, 8'h22, 8'h37, 8'h46, 8'h4D, 8'h32, 8'h30, 8'h11,
        8'h31, 8'h41, 8'h33, 8'h49, 8'h4B, 8'h4C
    };

    typedef enum logic [1:0] {
        KIND_LETTER,
        KIND_SPACE,
        KIND_NEWLINE,
        KIND_OTHER
    } kind_t;

    typedef enum logic [2:0] {
        SEG_MARK,
        SEG_ELEM_GAP,
        SEG_WORD_GAP,
        SEG_SENT_GAP,
        SEG_CHAR_GAP
    } seg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_GAP,
        ST_CLOSE
    } state_t;

    typedef struct packed {
        logic load_char;
        logic load_out;
        logic shift;
        seg_t seg_sel;
    } cmd_t;

    typedef struct packed {
        logic  out_free;
        kind_t kind;
        logic  cnt_zero;
    } stat_t;

endpackage

[rtl/core/mck_ctrl.sv]
module mck_ctrl
    import mck_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_tvalid,
    output logic  s_tready,
    input  stat_t stat,
    output cmd_t  cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_DISPATCH;
            end
            ST_DISPATCH: begin
                if (stat.out_free) begin
                    unique case (stat.kind)
                        KIND_LETTER:  state_next = stat.cnt_zero ? ST_IDLE : ST_GAP;
                        KIND_SPACE:   state_next = ST_CLOSE;
                        KIND_NEWLINE: state_next = ST_CLOSE;
                        KIND_OTHER:   state_next = ST_IDLE;
                        default:      state_next = ST_IDLE;
                    endcase
                end
            end
            ST_GAP: begin
                if (stat.out_free) state_next = ST_DISPATCH;
            end
            ST_CLOSE: begin
                if (stat.out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready      = 1'b0;
        cmd.load_char = 1'b0;
        cmd.load_out  = 1'b0;
        cmd.shift     = 1'b0;
        cmd.seg_sel   = SEG_CHAR_GAP;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready      = 1'b1;
                cmd.load_char = s_tvalid;
            end
            ST_DISPATCH: begin
                cmd.load_out = stat.out_free;
                unique case (stat.kind)
                    KIND_LETTER:  cmd.seg_sel = stat.cnt_zero ? SEG_CHAR_GAP : SEG_MARK;
                    KIND_SPACE:   cmd.seg_sel = SEG_WORD_GAP;
                    KIND_NEWLINE: cmd.seg_sel = SEG_SENT_GAP;
                    KIND_OTHER:   cmd.seg_sel = SEG_CHAR_GAP;
                    default:      cmd.seg_sel = SEG_CHAR_GAP;
                endcase
            end
            ST_GAP: begin
                cmd.load_out = stat.out_free;
                cmd.shift    = stat.out_free;
                cmd.seg_sel  = SEG_ELEM_GAP;
            end
            ST_CLOSE: begin
                cmd.load_out = stat.out_free;
                cmd.seg_sel  = SEG_CHAR_GAP;
            end
            default: ;
        endcase
    end

endmodule

[rtl/core/mck_dpath.sv]
module mck_dpath
    import mck_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [IDX_W-1:0]  cfg_addr,
    input  logic [DUR_W-1:0]  cfg_wr_data,
    input  logic [CHAR_W-1:0] char_code,
    input  cmd_t              cmd,
    output stat_t             stat,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              out_level,
    output logic [DUR_W-1:0]  out_dur,
    output logic              out_last
);

    logic [DUR_W-1:0] dot_reg, dash_reg, elem_gap_reg, char_gap_reg, word_gap_reg, sent_gap_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dot_reg      <= DOT_RST;
            dash_reg     <= DASH_RST;
            elem_gap_reg <= ELEM_GAP_RST;
            char_gap_reg <= CHAR_GAP_RST;
            word_gap_reg <= WORD_GAP_RST;
            sent_gap_reg <= SENT_GAP_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_DOT:      dot_reg      <= cfg_wr_data;
                REG_DASH:     dash_reg     <= cfg_wr_data;
                REG_ELEM_GAP: elem_gap_reg <= cfg_wr_data;
                REG_CHAR_GAP: char_gap_reg <= cfg_wr_data;
                REG_WORD_GAP: word_gap_reg <= cfg_wr_data;
                REG_SENT_GAP: sent_gap_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // character decode
    logic [CHAR_W-1:0] ofs;
    logic [7:0]        code;
    logic [CNT_W-1:0]  len;
    logic [PAT_W-1:0]  pat_aligned;
    kind_t             kind;

    assign ofs = char_code - CH_A;

    always_comb begin
        code = 8'h00;
        if (char_code >= CH_A && char_code <= CH_Z) begin
            code = LETTER_CODE[ofs[4:0]];
        end
        len         = code[6:4];
        // first element lands in the top bit
        pat_aligned = code[3:0] << (3'd4 - len);
        if (char_code >= CH_A && char_code <= CH_Z) begin
            kind = KIND_LETTER;
        end else if (char_code == CH_SPACE) begin
            kind = KIND_SPACE;
        end else if (char_code == CH_NEWLINE) begin
            kind = KIND_NEWLINE;
        end else begin
            kind = KIND_OTHER;
        end
    end

    kind_t            kind_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [PAT_W-1:0] pat_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kind_reg <= KIND_OTHER;
            cnt_reg  <= '0;
        end else if (cmd.load_char) begin
            kind_reg <= kind;
            cnt_reg  <= len;
        end else if (cmd.shift) begin
            cnt_reg  <= cnt_reg - 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_char) begin
            pat_reg <= pat_aligned;
        end else if (cmd.shift) begin
            pat_reg <= {pat_reg[PAT_W-2:0], 1'b0};
        end
    end

    // result register
    logic             valid_reg;
    logic             level_reg, last_reg;
    logic [DUR_W-1:0] dur_reg;
    logic             level_next, last_next;
    logic [DUR_W-1:0] dur_next;

    always_comb begin
        level_next = 1'b0;
        last_next  = 1'b0;
        dur_next   = char_gap_reg;
        unique case (cmd.seg_sel)
            SEG_MARK: begin
                level_next = 1'b1;
                dur_next   = pat_reg[PAT_W-1] ? dash_reg : dot_reg;
            end
            SEG_ELEM_GAP: dur_next = elem_gap_reg;
            SEG_WORD_GAP: dur_next = word_gap_reg;
            SEG_SENT_GAP: dur_next = sent_gap_reg;
            SEG_CHAR_GAP: last_next = 1'b1;
            default:      last_next = 1'b1;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            valid_reg <= 1'b1;
        end else if (out_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            level_reg <= level_next;
            dur_reg   <= dur_next;
            last_reg  <= last_next;
        end
    end

    assign stat.out_free = !valid_reg || out_ready;
    assign stat.kind     = kind_reg;
    assign stat.cnt_zero = (cnt_reg == '0);

    assign out_valid = valid_reg;
    assign out_level = level_reg;
    assign out_dur   = dur_reg;
    assign out_last  = last_reg;

endmodule

[rtl/core/morse_character_keyer.sv]
// channel  dir  handshake          payload
// s_       in   s_tvalid/s_tready  s_tdata[7:0] char_code
// m_       out  m_tvalid/m_tready  m_tdata[0] line_level, [16:1] duration_ms; m_tlast
// cfg_     in   cfg_wr_en          cfg_addr register index, cfg_wr_data value
//
// One character at a time: n segments (1..9); the character is first decoded and latched,
// then one segment per cycle goes into the output register while m_tready does not stall.
// The next character is taken while the closing segment still waits on m_tready.
// aresetn is synchronous, active low; registers return to their default timings.
// A stall on m_tready holds the sequencer until the output register frees.
module morse_character_keyer
    import mck_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [IDX_W-1:0]  cfg_addr,
    input  logic [DUR_W-1:0]  cfg_wr_data,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,   // [7:0] char_code
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [23:0]       m_tdata,   // [0] line_level, [16:1] duration_ms, [23:17] zero
    output logic              m_tlast
);

    cmd_t             cmd;
    stat_t            stat;
    logic             level;
    logic [DUR_W-1:0] dur;

    mck_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    mck_dpath u_dpath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .char_code   (s_tdata),
        .cmd         (cmd),
        .stat        (stat),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_level   (level),
        .out_dur     (dur),
        .out_last    (m_tlast)
    );

    assign m_tdata = {7'd0, dur, level};

endmodule

[verif/tb.sv]
`timescale 1ns / 100ps

module tb;
    import mck_pkg::*;

    localparam int NUM_TIMINGS  = 6;
    localparam int HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 16;
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        logic             level;
        logic [DUR_W-1:0] dur;
        logic             last;
    } key_segment_t;

    class keyer_scoreboard;
        logic [DUR_W-1:0] timing [NUM_TIMINGS];
        key_segment_t     segment_q[$];
        int               mismatches;

        function new();
            mismatches = 0;
            timing[REG_DOT]      = 16'd250;
            timing[REG_DASH]     = 16'd750;
            timing[REG_ELEM_GAP] = 16'd250;
            timing[REG_CHAR_GAP] = 16'd750;
            timing[REG_WORD_GAP] = 16'd1750;
            timing[REG_SENT_GAP] = 16'd2500;
        endfunction

        function void write_reg(int idx, logic [DUR_W-1:0] val);
            // unused indexes are ignored by the block
            if (idx <= int'(REG_SENT_GAP))
                timing[idx] = val;
        endfunction

        function string morse_of(int idx);
            case (idx)
                0:  return ".-";
                1:  return "-...";
                2:  return "-.-.";
                3:  return "-..";
                4:  return ".";
                5:  return "..-.";
                6:  return "--.";
                7:  return "....";
                8:  return "..";
                9:  return ".---";
                10: return "-.-";
                11: return ".-..";
                12: return "--";
                13: return "-.";
                14: return "---";
                15: return ".--.";
                16: return "--.-";
                17: return ".-.";
                18: return "...";
                19: return "-";
                20: return "..-";
                21: return "...-";
                22: return ".--";
                23: return "-..-";
                24: return "-.--";
                default: return "--..";
            endcase
        endfunction

        function void push(logic level, logic [DUR_W-1:0] dur, logic last);
            key_segment_t seg;
            seg.level = level;
            seg.dur   = dur;
            seg.last  = last;
            segment_q.push_back(seg);
        endfunction

        function void note_char(logic [CHAR_W-1:0] c);
            string pat;
            if (c >= CH_A && c <= CH_Z) begin
                pat = morse_of(int'(c) - int'(CH_A));
                for (int i = 0; i < pat.len(); i++) begin
                    push(1'b1, (pat[i] == "-") ? timing[REG_DASH] : timing[REG_DOT], 1'b0);
                    push(1'b0, timing[REG_ELEM_GAP], 1'b0);
                end
            end else if (c == CH_SPACE) begin
                push(1'b0, timing[REG_WORD_GAP], 1'b0);
            end else if (c == CH_NEWLINE) begin
                push(1'b0, timing[REG_SENT_GAP], 1'b0);
            end
            push(1'b0, timing[REG_CHAR_GAP], 1'b1);
        endfunction

        function void flag(string msg);
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t: %s", $time, msg);
        endfunction

        function void check_seg(logic [23:0] data, logic last);
            key_segment_t want;
            if (segment_q.size() == 0) begin
                flag($sformatf("unexpected segment level=%0b dur=%0d last=%0b",
                               data[0], data[16:1], last));
                return;
            end
            want = segment_q.pop_front();
            if (data[0] !== want.level || data[16:1] !== want.dur ||
                data[23:17] !== 7'd0 || last !== want.last)
                flag({$sformatf("segment mismatch: exp level=%0b dur=%0d last=%0b, ",
                                want.level, want.dur, want.last),
                      $sformatf("got level=%0b dur=%0d last=%0b pad=%h",
                                data[0], data[16:1], last, data[23:17])});
        endfunction

        function int pending();
            return segment_q.size();
        endfunction
    endclass

    logic              aclk        = 1'b0;
    logic              aresetn     = 1'b0;
    logic              cfg_wr_en   = 1'b0;
    logic [IDX_W-1:0]  cfg_addr    = '0;
    logic [DUR_W-1:0]  cfg_wr_data = '0;
    logic              s_tvalid    = 1'b0;
    logic              s_tready;
    logic [7:0]        s_tdata     = '0;
    logic              m_tvalid;
    logic              m_tready    = 1'b0;
    logic [23:0]       m_tdata;
    logic              m_tlast;

    keyer_scoreboard   sb = new();

    int src_idle_pct = 28;
    int dst_idle_pct = 54;
    int hold_seq     = 0;
    int hold_seen    = 0;
    int hold_left    = 0;
    int quiet_cycles = 0;

    logic [DUR_W-1:0] next_timing [NUM_TIMINGS];

    morse_character_keyer DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // sample both channels with the values seen by the block at this edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                sb.note_char(s_tdata);
            if (m_tvalid && m_tready)
                sb.check_seg(m_tdata, m_tlast);
        end
    end

    // receiver; a long hold-off starts whenever hold_seq moves
    always @(posedge aclk) begin
        if (hold_seen != hold_seq) begin
            hold_seen = hold_seq;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= dst_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // request stays high into the next one unless a gap is drawn
    task automatic send_char(input logic [7:0] c);
        if ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < src_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // one edge first so the last accepted request is already noted
    task automatic drain();
        @(posedge aclk);
        while (sb.pending() > 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic apply_timings();
        logic [DUR_W-1:0] val;
        for (int i = 0; i < 2 ** IDX_W; i++) begin
            val = (i < NUM_TIMINGS) ? next_timing[i] : DUR_W'($urandom);
            cfg_wr_en   <= 1'b1;
            cfg_addr    <= IDX_W'(i);
            cfg_wr_data <= val;
            @(posedge aclk);
            sb.write_reg(i, val);
        end
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [7:0] pick_char();
        int r;
        r = $urandom_range(99);
        if (r < 62)
            return CH_A + 8'($urandom_range(25));
        else if (r < 72)
            return CH_SPACE;
        else if (r < 80)
            return CH_NEWLINE;
        else
            return 8'($urandom_range(255));
    endfunction

    task automatic send_random(input int count, input bit with_hold);
        for (int n = 0; n < count; n++) begin
            if (with_hold && n == 10)
                hold_seq <= hold_seq + 1;
            send_char(pick_char());
        end
    endtask

    task automatic set_all(input logic [DUR_W-1:0] val);
        for (int i = 0; i < NUM_TIMINGS; i++)
            next_timing[i] = val;
    endtask

    initial begin
        logic [7:0] directed [$];
        directed = '{8'h61, 8'h65, 8'h74, 8'h62, 8'h71, 8'h7A, 8'h68, 8'h6F,
                     CH_SPACE, CH_NEWLINE, 8'h41, 8'h5A, 8'h00, 8'hFF, 8'h60,
                     8'h7B, 8'h09, 8'h0B, 8'h1F, 8'h21, 8'h80, 8'h7F, 8'h6A};

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // defaults straight out of reset
        foreach (directed[i])
            send_char(directed[i]);
        s_tvalid <= 1'b0;
        drain();

        set_all(16'hFFFF);
        apply_timings();
        send_random(60, 1'b0);
        s_tvalid <= 1'b0;
        drain();

        src_idle_pct <= 54;
        dst_idle_pct <= 28;
        set_all(16'h0000);
        apply_timings();
        send_random(60, 1'b0);
        s_tvalid <= 1'b0;
        drain();

        set_all(16'h0001);
        apply_timings();
        send_random(60, 1'b0);
        s_tvalid <= 1'b0;
        drain();

        src_idle_pct <= 0;
        dst_idle_pct <= 0;
        for (int i = 0; i < NUM_TIMINGS; i++)
            next_timing[i] = DUR_W'($urandom);
        apply_timings();
        send_random(80, 1'b1);
        s_tvalid <= 1'b0;
        drain();

        for (int i = 0; i < NUM_TIMINGS; i++)
            next_timing[i] = DUR_W'($urandom_range(1, 65535));
        apply_timings();
        send_random(90, 1'b0);
        s_tvalid <= 1'b0;
        drain();

        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
